@@ sv/fdf_pkg.sv @@
// Shared constants, types and register codes for the fractional derivative FIR core.
`timescale 1ns / 1ps
`default_nettype none

package fdf_pkg;

  // Filter length and derived index widths
  localparam int TAPS   = 64;
  localparam int TAP_AW = $clog2(TAPS);
  localparam int CNT_W  = $clog2(TAPS + 1);

  // Field widths
  localparam int SAMPLE_W = 32;
  localparam int WEIGHT_W = 48;
  localparam int EXP_W    = 16;
  localparam int SCALE_W  = 48;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OUT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OUT    = 3'd4;

  // Input item actions
  localparam logic ACT_SAMPLE  = 1'b0;
  localparam logic ACT_REBUILD = 1'b1;

  // Shared multiplier: 24 x 32 unsigned, registered product
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Reciprocal table entries, Q24 (entry for 1 is exactly 2^24)
  localparam int RECIP_W = 25;

  // Numeric constants
  localparam logic [WEIGHT_W-1:0] W_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [WEIGHT_W-1:0] ONE_Q24 = 48'h0000_0100_0000;
  localparam int                  EXP_MIN = -4096;
  localparam logic [SAMPLE_W-1:0] INT32_MAX = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] INT32_MIN = 32'h8000_0000;

  // Signed (i-1)*4096 - exponent
  localparam int F_W = TAP_AW + 14;

  // One signed tap product and the running sum
  localparam int TERM_W = 58;
  localparam int ACC_W  = TERM_W + TAP_AW + 1;

  // Request to the shared multiplier
  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

`default_nettype wire

@@ sv/fdf_in_if.sv @@
// Input channel interface: action and sample with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface fdf_in_if import fdf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output action, output sample, input ready);
  modport sink   (input valid, input action, input sample, output ready);
endinterface

`default_nettype wire

@@ sv/fdf_out_if.sv @@
// Result channel interface: clamped and raw filter output with limit flags.
`timescale 1ns / 1ps
`default_nettype none

interface fdf_out_if import fdf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] result;
  logic signed [SAMPLE_W-1:0] raw_result;
  logic                       hit_upper;
  logic                       hit_lower;

  modport source (output valid, output result, output raw_result, output hit_upper,
                  output hit_lower, input ready);
  modport sink   (input valid, input result, input raw_result, input hit_upper,
                  input hit_lower, output ready);
endinterface

`default_nettype wire

@@ sv/fdf_cfg_if.sv @@
// Configuration write channel interface: register index and write data.
`timescale 1ns / 1ps
`default_nettype none

interface fdf_cfg_if import fdf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/fdf_mul.sv @@
// Shared 24 x 32 unsigned multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none

module fdf_mul import fdf_pkg::*; (
  input  logic               clk,
  input  mul_req_t           req,
  output logic [MUL_P_W-1:0] prod_r
);

  logic [MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = MUL_P_W'(req.a) * MUL_P_W'(req.b);

  // product holds until the sequencer issues the next pass
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/fractional_derivative_fir_core.sv @@
// Top level: fractional-order derivative FIR with shared multiplier sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Grunwald-Letnikov fractional derivative as a TAPS-long FIR on signed Q16.16
// samples. A rebuild transaction (action 1) recomputes all tap weights from the
// exponent and scale registers and clears the sample history; it returns no
// result and keeps the input busy until the last tap weight is written.
// A sample transaction (action 0) returns one result and keeps the input busy
// while it works through the taps: every tap takes two passes through the
// single 24x32 multiplier, since a 48-bit weight times a 32-bit sample is split
// into a low and a high partial product. A finished result sits in an output
// register, so the next transaction is accepted while it waits to be taken;
// only when the previous result is still waiting does a sample stall longer,
// until that result is taken.
// Configuration writes are accepted in every cycle and must only be issued
// while the core is idle. Tap weights and history live in RAMs with one read
// and one write port; no clearing pass is needed after reset (a fill count and
// a weights-built flag stand in for the reset contents).
module fractional_derivative_fir_core import fdf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  fdf_in_if.sink     in_chan,
  fdf_out_if.source  out_chan,
  fdf_cfg_if.sink    cfg_chan
);

  // Sequencer state codes
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PRIME  = 4'd1;
  localparam logic [3:0] ST_LOAD   = 4'd2;
  localparam logic [3:0] ST_MLO    = 4'd3;
  localparam logic [3:0] ST_MHI    = 4'd4;
  localparam logic [3:0] ST_TERM   = 4'd5;
  localparam logic [3:0] ST_ACC    = 4'd6;
  localparam logic [3:0] ST_SAT    = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;
  localparam logic [3:0] ST_RF     = 4'd9;
  localparam logic [3:0] ST_RRAT   = 4'd10;
  localparam logic [3:0] ST_RWLO   = 4'd11;
  localparam logic [3:0] ST_RWHI   = 4'd12;
  localparam logic [3:0] ST_RWCOMB = 4'd13;

  function automatic logic [TAP_AW-1:0] ptr_inc(input logic [TAP_AW-1:0] p);
    ptr_inc = (p == TAP_AW'(TAPS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TAP_AW-1:0] ptr_dec(input logic [TAP_AW-1:0] p);
    ptr_dec = (p == '0) ? TAP_AW'(TAPS - 1) : p - 1'b1;
  endfunction

  // Configuration registers
  logic signed [EXP_W-1:0]    exponent_r;
  logic [SCALE_W-1:0]         scale_r;
  logic                       sat_enable_r;
  logic signed [SAMPLE_W-1:0] max_out_r;
  logic signed [SAMPLE_W-1:0] min_out_r;

  // Sequencer and datapath registers
  logic [3:0]                 state_r;
  logic [3:0]                 state_nxt;
  logic [CNT_W-1:0]           cnt_r;
  logic [TAP_AW-1:0]          head_r;
  logic [TAP_AW-1:0]          hp_r;
  logic [CNT_W-1:0]           fill_r;
  logic                       built_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [TERM_W-1:0]   term_r;
  logic [31:0]                part_r;
  logic [WEIGHT_W-2:0]        wm_r;
  logic [SAMPLE_W-1:0]        xm_r;
  logic                       neg_r;
  logic                       tneg_r;
  logic signed [EXP_W-1:0]    e_r;
  logic [WEIGHT_W-2:0]        wmag_r;
  logic                       wneg_r;
  logic [F_W-1:0]             fm_r;
  logic                       fneg_r;
  logic [MUL_A_W-1:0]         rm_r;
  logic signed [SAMPLE_W-1:0] raw_r;

  // Output register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_result_r;
  logic signed [SAMPLE_W-1:0] out_raw_r;
  logic                       out_hu_r;
  logic                       out_hl_r;

  // Memories
  logic [SAMPLE_W-1:0]        hmem [TAPS];
  logic [WEIGHT_W-1:0]        wmem [TAPS];
  logic [SAMPLE_W-1:0]        h_q;
  logic [WEIGHT_W-1:0]        w_q;

  // Combinational nets
  logic                       in_acc;
  logic                       out_free;
  logic [TAP_AW-1:0]          head_inc;
  logic                       h_we;
  logic                       w_we;
  logic [TAP_AW-1:0]          w_wa;
  logic [WEIGHT_W-1:0]        w_wd;
  logic [TAP_AW-1:0]          w_ra;
  logic [CNT_W-1:0]           k_issue;
  logic [CNT_W-1:0]           k_load;
  logic [WEIGHT_W-1:0]        w_eff;
  logic [WEIGHT_W-1:0]        w_eff_neg;
  logic [SAMPLE_W-1:0]        x_eff;
  logic [SAMPLE_W-1:0]        x_eff_neg;
  logic [WEIGHT_W-2:0]        wm_v;
  logic [SAMPLE_W-1:0]        xm_v;
  logic [WEIGHT_W-2:0]        w0_mag;
  logic signed [EXP_W-1:0]    e0;
  logic [F_W-1:0]             f_base;
  logic signed [F_W-1:0]      f_val;
  logic [F_W-1:0]             f_neg;
  logic [MUL_P_W-1:0]         prod_r;
  mul_req_t                   mreq;
  logic [MUL_P_W:0]           qm;
  logic signed [TERM_W-1:0]   term_v;
  logic [MUL_P_W+4:0]         pm_full;
  logic [WEIGHT_W-2:0]        pm_sat;
  logic                       wneg_new;
  logic [WEIGHT_W-1:0]        w_new;
  logic [ACC_W-32:0]          acc_hi;
  logic signed [SAMPLE_W-1:0] raw_v;
  logic signed [SAMPLE_W-1:0] res_hi;
  logic signed [SAMPLE_W-1:0] res_v;
  logic                       hu_v;
  logic                       hl_v;
  logic [RECIP_W-1:0]         recip_tab [TAPS];

  // Reciprocal table, round(2^24 / i), worked out at elaboration
  for (genvar g = 0; g < TAPS; g++) begin : g_recip
    localparam longint unsigned RV = ((64'd1 << 24) + g / 2) / ((g == 0) ? 1 : g);
    assign recip_tab[g] = RECIP_W'(RV);
  end

  // Handshakes
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_free       = !out_valid_r || out_chan.ready;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.result     = out_result_r;
  assign out_chan.raw_result = out_raw_r;
  assign out_chan.hit_upper  = out_hu_r;
  assign out_chan.hit_lower  = out_hl_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r   <= '0;
      scale_r      <= SCALE_W'(ONE_Q24);
      sat_enable_r <= 1'b0;
      max_out_r    <= INT32_MAX;
      min_out_r    <= INT32_MIN;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_EXPONENT:   exponent_r   <= cfg_chan.data[EXP_W-1:0];
        REG_SCALE:      scale_r      <= cfg_chan.data[SCALE_W-1:0];
        REG_SAT_ENABLE: sat_enable_r <= cfg_chan.data[0];
        REG_MAX_OUT:    max_out_r    <= cfg_chan.data[SAMPLE_W-1:0];
        REG_MIN_OUT:    min_out_r    <= cfg_chan.data[SAMPLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // First tap and effective exponent for a rebuild
  always_comb begin
    if ($signed(exponent_r) < EXP_MIN) begin
      e0     = '0;
      w0_mag = ONE_Q24[WEIGHT_W-2:0];
    end else begin
      e0     = exponent_r;
      w0_mag = (scale_r > W_MAX) ? W_MAX[WEIGHT_W-2:0] : scale_r[WEIGHT_W-2:0];
    end
  end

  // Memory addressing
  assign head_inc = ptr_inc(head_r);
  assign h_we     = in_acc && (in_chan.action == ACT_SAMPLE);
  assign k_issue  = (state_r == ST_PRIME) ? '0 : cnt_r + 1'b1;
  assign w_ra     = (k_issue >= CNT_W'(TAPS)) ? '0 : k_issue[TAP_AW-1:0];
  assign w_we     = (in_acc && (in_chan.action == ACT_REBUILD)) || (state_r == ST_RWCOMB);
  assign w_wa     = (state_r == ST_RWCOMB) ? cnt_r[TAP_AW-1:0] : '0;
  assign w_wd     = (state_r == ST_RWCOMB) ? w_new : {1'b0, w0_mag};

  // Sample history RAM (circular, newest at head)
  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[head_inc] <= in_chan.sample;
    end
    h_q <= hmem[hp_r];
  end

  // Tap weight RAM
  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_wa] <= w_wd;
    end
    w_q <= wmem[w_ra];
  end

  // Operands for the next tap: entries past the fill count read as zero,
  // weights before the first rebuild read as the reset taps
  assign k_load    = (state_r == ST_LOAD) ? '0 : cnt_r + 1'b1;
  assign w_eff     = built_r ? w_q : ((k_load == '0) ? ONE_Q24 : '0);
  assign x_eff     = (k_load < fill_r) ? h_q : '0;
  assign w_eff_neg = -w_eff;
  assign x_eff_neg = -x_eff;
  assign wm_v      = w_eff[WEIGHT_W-1] ? w_eff_neg[WEIGHT_W-2:0] : w_eff[WEIGHT_W-2:0];
  assign xm_v      = x_eff[SAMPLE_W-1] ? x_eff_neg : x_eff;

  // Tap product from the two partial products, with sign
  assign qm     = {1'b0, prod_r} + (MUL_P_W + 1)'(part_r);
  assign term_v = tneg_r ? -TERM_W'(qm) : TERM_W'(qm);

  // Ratio numerator f = (i-1)*4096 - e
  assign f_base = F_W'(cnt_r - CNT_W'(1)) << 12;
  assign f_val  = $signed(f_base) - F_W'(e_r);
  assign f_neg  = -f_val;

  // New weight magnitude, saturated
  assign pm_full  = {1'b0, prod_r, 4'b0} + (MUL_P_W + 5)'(part_r);
  assign pm_sat   = (pm_full > (MUL_P_W + 5)'(W_MAX)) ? W_MAX[WEIGHT_W-2:0]
                                                      : pm_full[WEIGHT_W-2:0];
  assign wneg_new = (fneg_r ^ wneg_r) && (pm_sat != '0);
  assign w_new    = wneg_new ? -{1'b0, pm_sat} : {1'b0, pm_sat};

  // Clip the sum to 32 bits
  assign acc_hi = acc_r[ACC_W-1:31];
  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      raw_v = acc_r[SAMPLE_W-1:0];
    end else begin
      raw_v = acc_r[ACC_W-1] ? INT32_MIN : INT32_MAX;
    end
  end

  // Output limits: upper first, then lower
  assign hu_v   = sat_enable_r && (raw_r > max_out_r);
  assign res_hi = hu_v ? max_out_r : raw_r;
  assign hl_v   = sat_enable_r && (res_hi < min_out_r);
  assign res_v  = hl_v ? min_out_r : res_hi;

  // Shared multiplier operand select
  always_comb begin
    mreq = '0;
    case (state_r)
      ST_MLO: begin
        mreq.en = 1'b1;
        mreq.a  = wm_r[MUL_A_W-1:0];
        mreq.b  = xm_r;
      end
      ST_MHI: begin
        mreq.en = 1'b1;
        mreq.a  = MUL_A_W'(wm_r[WEIGHT_W-2:MUL_A_W]);
        mreq.b  = xm_r;
      end
      ST_RRAT: begin
        mreq.en = 1'b1;
        mreq.a  = MUL_A_W'(fm_r);
        mreq.b  = MUL_B_W'(recip_tab[cnt_r[TAP_AW-1:0]]);
      end
      ST_RWLO: begin
        mreq.en = 1'b1;
        mreq.a  = prod_r[16 +: MUL_A_W];
        mreq.b  = MUL_B_W'(wmag_r[MUL_A_W-1:0]);
      end
      ST_RWHI: begin
        mreq.en = 1'b1;
        mreq.a  = rm_r;
        mreq.b  = MUL_B_W'(wmag_r[WEIGHT_W-2:MUL_A_W]);
      end
      default: begin
      end
    endcase
  end

  fdf_mul u_mul (
    .clk    (clk),
    .req    (mreq),
    .prod_r (prod_r)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_chan.action == ACT_REBUILD) ? ST_RF : ST_PRIME;
        end
      end
      ST_PRIME:  state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_MLO;
      ST_MLO:    state_nxt = ST_MHI;
      ST_MHI:    state_nxt = (cnt_r == CNT_W'(TAPS - 1)) ? ST_TERM : ST_MLO;
      ST_TERM:   state_nxt = ST_ACC;
      ST_ACC:    state_nxt = ST_SAT;
      ST_SAT:    state_nxt = ST_OUT;
      ST_OUT:    state_nxt = out_free ? ST_IDLE : ST_OUT;
      ST_RF:     state_nxt = ST_RRAT;
      ST_RRAT:   state_nxt = ST_RWLO;
      ST_RWLO:   state_nxt = ST_RWHI;
      ST_RWHI:   state_nxt = ST_RWCOMB;
      ST_RWCOMB: state_nxt = (cnt_r == CNT_W'(TAPS - 1)) ? ST_IDLE : ST_RF;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      fill_r  <= '0;
      built_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (in_chan.action == ACT_REBUILD) begin
          fill_r  <= '0;
          built_r <= 1'b1;
        end else begin
          head_r <= head_inc;
          fill_r <= (fill_r == CNT_W'(TAPS)) ? fill_r : fill_r + 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        acc_r  <= '0;
        hp_r   <= head_inc;
        cnt_r  <= CNT_W'(1);
        e_r    <= e0;
        wmag_r <= w0_mag;
        wneg_r <= 1'b0;
      end
      ST_PRIME: begin
        hp_r <= ptr_dec(hp_r);
      end
      ST_LOAD: begin
        cnt_r <= '0;
        wm_r  <= wm_v;
        xm_r  <= xm_v;
        neg_r <= w_eff[WEIGHT_W-1] ^ x_eff[SAMPLE_W-1];
      end
      ST_MLO: begin
        hp_r   <= ptr_dec(hp_r);
        term_r <= (cnt_r == '0) ? '0 : term_v;
      end
      ST_MHI: begin
        part_r <= prod_r[MUL_P_W-1:24];
        tneg_r <= neg_r;
        wm_r   <= wm_v;
        xm_r   <= xm_v;
        neg_r  <= w_eff[WEIGHT_W-1] ^ x_eff[SAMPLE_W-1];
        acc_r  <= acc_r + ACC_W'(term_r);
        cnt_r  <= cnt_r + 1'b1;
      end
      ST_TERM: begin
        term_r <= term_v;
      end
      ST_ACC: begin
        acc_r <= acc_r + ACC_W'(term_r);
      end
      ST_SAT: begin
        raw_r <= raw_v;
      end
      ST_RF: begin
        fneg_r <= f_val[F_W-1];
        fm_r   <= f_val[F_W-1] ? f_neg : f_val;
      end
      ST_RWLO: begin
        rm_r <= prod_r[16 +: MUL_A_W];
      end
      ST_RWHI: begin
        part_r <= prod_r[51:20];
      end
      ST_RWCOMB: begin
        wmag_r <= pm_sat;
        wneg_r <= wneg_new;
        cnt_r  <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register: loads when empty or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_OUT) && out_free) begin
      out_result_r <= res_v;
      out_raw_r    <= raw_r;
      out_hu_r     <= hu_v;
      out_hl_r     <= hl_v;
    end
  end

endmodule

`default_nettype wire

@@ sv/fdf_checker.sv @@
// Port-level checker for the fractional derivative FIR core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fdf_checker import fdf_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_result,
  input logic signed [SAMPLE_W-1:0] out_raw_result,
  input logic                       out_hit_upper,
  input logic                       out_hit_lower
);

  // core is busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an accepted transaction");

  // no result can appear in the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared one cycle after accept");

  // unclamped result equals the raw sum
  a_no_hit_passthru: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit_upper && !out_hit_lower) |-> (out_result == out_raw_result))
    else $error("result differs from raw sum without a limit hit");

  // upper limit only ever lowers the output
  a_upper_lowers: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit_upper && !out_hit_lower) |-> (out_result < out_raw_result))
    else $error("upper limit hit without lowering the output");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result)
                                    && $stable(out_raw_result)))
    else $error("stalled result changed or dropped");

endmodule

bind fractional_derivative_fir_core fdf_checker u_fdf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_result     (out_chan.result),
  .out_raw_result (out_chan.raw_result),
  .out_hit_upper  (out_chan.hit_upper),
  .out_hit_lower  (out_chan.hit_lower)
);

`default_nettype wire

@@ tb/sv/fdf_checker.sv @@
// Scoreboard for the fractional derivative FIR core: predicts every filter output and checks it.
`timescale 1ns / 1ps

module fdf_scoreboard import fdf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  fdf_in_if    in_mon,
  fdf_out_if   out_mon,
  fdf_cfg_if   cfg_mon,
  output int   errors,
  output int   pending,
  output int   results_seen
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] result;
    logic signed [SAMPLE_W-1:0] raw_result;
    logic                       hit_upper;
    logic                       hit_lower;
  } fir_out_t;

  localparam longint RAW_HI = longint'($signed(INT32_MAX));
  localparam longint RAW_LO = longint'($signed(INT32_MIN));

  // Depth of the prediction ring, far above what the core can hold in flight
  localparam int PRED_DEPTH = 256;

  // Shadow copy of the register file
  logic        [EXP_W-1:0]    exp_reg;
  logic        [SCALE_W-1:0]  scale_reg;
  logic                       sat_en_reg;
  logic signed [SAMPLE_W-1:0] max_reg;
  logic signed [SAMPLE_W-1:0] min_reg;

  // Filter state: history[0] is the newest sample, weights kept as signed Q24.24
  longint   history [TAPS];
  longint   weights [TAPS];

  // Predicted results in order, with running write and read counts
  fir_out_t pred_buf [PRED_DEPTH];
  int       wr_cnt;
  int       rd_cnt;

  function automatic longint unsigned abs_mag(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // Grunwald-Letnikov weights: w0 = scale, wi = w(i-1) * (i-1-exp) / i
  function automatic void rebuild_taps();
    longint            ex, w, f;
    longint unsigned   recip, ratio, wm, pm;
    int                i;
    ex = longint'($signed(exp_reg));
    if (ex < EXP_MIN) begin
      // order below -1.0 falls back to a plain pass-through
      ex = 0;
      w  = longint'(ONE_Q24);
    end else begin
      w = (scale_reg > W_MAX) ? longint'(W_MAX) : longint'(scale_reg);
    end
    weights[0] = w;
    for (i = 1; i < TAPS; i++) begin
      f     = longint'(i - 1) * 4096 - ex;
      recip = (64'd16777216 + 64'(i / 2)) / 64'(i);
      ratio = (abs_mag(f) * recip) >> 16;
      wm    = abs_mag(w);
      pm    = (wm >> 20) * ratio + (((wm & 64'hF_FFFF) * ratio) >> 20);
      if (pm > W_MAX)
        pm = W_MAX;
      w = ((f < 0) != (w < 0)) ? -longint'(pm) : longint'(pm);
      weights[i] = w;
    end
    for (i = 0; i < TAPS; i++)
      history[i] = 0;
  endfunction

  // Shift in one sample, convolve, clip to 32 bits, then apply the limits
  function automatic fir_out_t filter_sample(input logic signed [SAMPLE_W-1:0] smp);
    fir_out_t        o;
    longint          acc, t, raw, res;
    longint unsigned wm, xm, qm;
    int              i;
    for (i = TAPS - 1; i > 0; i--)
      history[i] = history[i - 1];
    history[0] = longint'(smp);
    acc = 0;
    for (i = 0; i < TAPS; i++) begin
      wm  = abs_mag(weights[i]);
      xm  = abs_mag(history[i]);
      qm  = (wm >> 24) * xm + (((wm & 64'hFF_FFFF) * xm) >> 24);
      t   = ((weights[i] < 0) != (history[i] < 0)) ? -longint'(qm) : longint'(qm);
      acc += t;
    end
    if (acc > RAW_HI)
      raw = RAW_HI;
    else if (acc < RAW_LO)
      raw = RAW_LO;
    else
      raw = acc;
    res = raw;
    o.hit_upper = 1'b0;
    o.hit_lower = 1'b0;
    if (sat_en_reg) begin
      // upper limit first, lower limit last so it wins when they cross
      if (res > longint'(max_reg)) begin
        res = longint'(max_reg);
        o.hit_upper = 1'b1;
      end
      if (res < longint'(min_reg)) begin
        res = longint'(min_reg);
        o.hit_lower = 1'b1;
      end
    end
    o.result     = res[SAMPLE_W-1:0];
    o.raw_result = raw[SAMPLE_W-1:0];
    return o;
  endfunction

  // Watch all three channels at each rising edge
  always @(posedge clk) begin : monitor
    fir_out_t want, got;
    int       k;
    if (!rst_n) begin
      exp_reg    = '0;
      scale_reg  = SCALE_W'(ONE_Q24);
      sat_en_reg = 1'b0;
      max_reg    = INT32_MAX;
      min_reg    = INT32_MIN;
      for (k = 0; k < TAPS; k++) begin
        history[k] = 0;
        weights[k] = 0;
      end
      weights[0] = longint'(ONE_Q24);
      wr_cnt       = 0;
      rd_cnt       = 0;
      errors       = 0;
      results_seen = 0;
    end else begin
      // register write transaction
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_EXPONENT:   exp_reg    = cfg_mon.data[EXP_W-1:0];
          REG_SCALE:      scale_reg  = cfg_mon.data[SCALE_W-1:0];
          REG_SAT_ENABLE: sat_en_reg = cfg_mon.data[0];
          REG_MAX_OUT:    max_reg    = cfg_mon.data[SAMPLE_W-1:0];
          REG_MIN_OUT:    min_reg    = cfg_mon.data[SAMPLE_W-1:0];
          default: ;
        endcase
      end

      // input transaction: rebuild gives nothing back, a sample gives one result
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == ACT_REBUILD) begin
          rebuild_taps();
        end else begin
          pred_buf[wr_cnt % PRED_DEPTH] = filter_sample(in_mon.sample);
          wr_cnt++;
        end
      end

      // result transaction against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got.result     = out_mon.result;
        got.raw_result = out_mon.raw_result;
        got.hit_upper  = out_mon.hit_upper;
        got.hit_lower  = out_mon.hit_lower;
        results_seen++;
        if (wr_cnt == rd_cnt) begin
          if (errors < 10)
            $display("[%0t] unexpected result: result %0d raw %0d hits %b%b",
                     $time, got.result, got.raw_result, got.hit_upper, got.hit_lower);
          errors++;
        end else begin
          want = pred_buf[rd_cnt % PRED_DEPTH];
          rd_cnt++;
          if (got !== want) begin
            if (errors < 10)
              $display({"[%0t] mismatch: expected result %0d raw %0d hits %b%b, ",
                        "got result %0d raw %0d hits %b%b"},
                       $time, want.result, want.raw_result, want.hit_upper, want.hit_lower,
                       got.result, got.raw_result, got.hit_upper, got.hit_lower);
            errors++;
          end
        end
      end
    end
    pending = wr_cnt - rd_cnt;
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the fractional derivative FIR core: stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb import fdf_pkg::*; ();

  logic clk;
  logic rst_n;

  fdf_in_if  in_bus ();
  fdf_out_if out_bus ();
  fdf_cfg_if cfg_bus ();

  int         mismatches;
  int         outstanding;
  int         results_seen;
  int         burst_left;
  int         rebuilds;
  int         settings_used;
  logic [9:0] stall_tick = '0;

  fractional_derivative_fir_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  fdf_scoreboard scoreboard (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .cfg_mon      (cfg_bus),
    .errors       (mismatches),
    .pending      (outstanding),
    .results_seen (results_seen)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Result side stalls: four modes in turn, picked by the top bits of stall_tick
  always @(posedge clk) begin
    stall_tick <= stall_tick + 10'd1;
    case (stall_tick[9:8])
      2'd0:    out_bus.ready <= 1'b1;
      2'd1:    out_bus.ready <= ($urandom_range(0, 1) == 1);
      2'd2:    out_bus.ready <= (stall_tick[2:0] == 3'd0);
      default: out_bus.ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // One input transaction; bursts of random length separated by idle gaps
  task automatic feed(input logic act, input logic [SAMPLE_W-1:0] smp);
    if (burst_left == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 200)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_bus.valid  <= 1'b1;
    in_bus.action <= act;
    in_bus.sample <= smp;
    if (act == ACT_REBUILD)
      rebuilds++;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    burst_left--;
  endtask

  // One register write transaction; valid is left high for back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [EXP_W-1:0] ex, input logic [SCALE_W-1:0] sc,
                              input logic sat, input logic [SAMPLE_W-1:0] hi,
                              input logic [SAMPLE_W-1:0] lo);
    write_reg(REG_EXPONENT, CFG_DATA_W'(ex));
    write_reg(REG_SCALE, CFG_DATA_W'(sc));
    write_reg(REG_SAT_ENABLE, CFG_DATA_W'(sat));
    write_reg(REG_MAX_OUT, CFG_DATA_W'(hi));
    write_reg(REG_MIN_OUT, CFG_DATA_W'(lo));
    cfg_bus.valid <= 1'b0;
    settings_used++;
  endtask

  // Hold input until every result is back, then cover a trailing rebuild
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    logic [EXP_W-1:0]    ex;
    logic [SCALE_W-1:0]  sc;
    logic                sat;
    logic [SAMPLE_W-1:0] hi, lo, smp;
    int                  ph, pick;

    rst_n         <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.action <= ACT_SAMPLE;
    in_bus.sample <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_EXPONENT;
    cfg_bus.data  <= '0;
    burst_left    = 0;
    rebuilds      = 0;
    settings_used = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset taps pass samples straight through
    feed(ACT_SAMPLE, INT32_MAX);
    feed(ACT_SAMPLE, INT32_MIN);
    feed(ACT_SAMPLE, '0);
    feed(ACT_SAMPLE, '1);
    feed(ACT_SAMPLE, 32'd1);
    feed(ACT_SAMPLE, 32'h5555_5555);

    // Order 1.0: first difference, saturating both ways
    settle();
    program_regs(16'h1000, SCALE_W'(ONE_Q24), 1'b0, INT32_MAX, INT32_MIN);
    feed(ACT_REBUILD, 32'hDEAD_BEEF);
    feed(ACT_SAMPLE, INT32_MAX);
    feed(ACT_SAMPLE, INT32_MIN);
    feed(ACT_SAMPLE, INT32_MAX);
    feed(ACT_SAMPLE, '0);

    // Order below -1.0: scale ignored, unit first tap
    settle();
    program_regs(16'h8000, '1, 1'b0, INT32_MAX, INT32_MIN);
    feed(ACT_REBUILD, '0);
    feed(ACT_SAMPLE, 32'h1234_5678);
    feed(ACT_SAMPLE, '1);

    // Oversized scale: first tap saturates
    settle();
    program_regs(16'h0800, '1, 1'b1, INT32_MAX, INT32_MIN);
    feed(ACT_REBUILD, '1);
    feed(ACT_SAMPLE, 32'd1);
    feed(ACT_SAMPLE, '1);
    feed(ACT_SAMPLE, INT32_MAX);

    // Crossed limits: both clamps fire, lower one wins
    settle();
    program_regs('0, SCALE_W'(ONE_Q24), 1'b1, -32'sd6553600, 32'sd6553600);
    feed(ACT_REBUILD, '0);
    feed(ACT_SAMPLE, '0);
    feed(ACT_SAMPLE, 32'sd65536000);

    // Random phases, each a rebuild followed by a run of samples with rare rebuilds mixed in
    for (ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0:       ex = 16'hF000;
        1:       ex = 16'h4000;
        2, 6:    ex = EXP_W'($urandom());
        default: ex = EXP_W'($urandom_range(0, 20480) - 4096);
      endcase
      case (ph)
        3:       sc = '0;
        4:       sc = '1;
        6:       sc = SCALE_W'({$urandom(), $urandom()});
        default: sc = SCALE_W'($urandom_range(1 << 20, 1 << 28));
      endcase
      sat = (ph % 3) != 0;
      if (ph == 5) begin
        hi = INT32_MIN;
        lo = INT32_MAX;
      end else if (ph == 7) begin
        hi = INT32_MAX;
        lo = INT32_MIN;
      end else begin
        hi = $urandom_range(0, 32'h0800_0000);
        lo = 32'd0 - $urandom_range(0, 32'h0800_0000);
      end
      program_regs(ex, sc, sat, hi, lo);
      feed(ACT_REBUILD, $urandom());
      repeat (50) begin
        if ($urandom_range(0, 24) == 0) begin
          feed(ACT_REBUILD, $urandom());
        end else begin
          pick = $urandom_range(0, 9);
          if (pick < 6)
            smp = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
          else if (pick < 8)
            smp = $urandom();
          else if (pick == 8)
            case ($urandom_range(0, 3))
              0:       smp = INT32_MAX;
              1:       smp = INT32_MIN;
              2:       smp = '0;
              default: smp = '1;
            endcase
          else
            smp = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
          feed(ACT_SAMPLE, smp);
        end
      end
    end

    // Drain and report
    settle();
    $display("Covered %0d filter results over %0d register settings and %0d tap rebuilds.",
             results_seen, settings_used, rebuilds);
    if (mismatches == 0 && outstanding == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still outstanding", outstanding);
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ fractional_derivative_fir_core.f @@
sv/fdf_pkg.sv
sv/fdf_in_if.sv
sv/fdf_out_if.sv
sv/fdf_cfg_if.sv
sv/fdf_mul.sv
sv/fractional_derivative_fir_core.sv
sv/fdf_checker.sv
tb/sv/fdf_checker.sv
tb/sv/tb.sv
